// ----- rtl/frame_receiver_double_buffer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the frame receiver
// Clocked same-cycle and next-cycle implication checks, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_RECEIVER_DOUBLE_BUFFER_MACROS_SVH
`define FRAME_RECEIVER_DOUBLE_BUFFER_MACROS_SVH

// same-cycle implication
`define FRB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/frb_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame receiver package
// Result codes, result item type and fixed constants shared by all modules.
// ----------------------------------------------------------------------------
package frb_pkg;

  // result event codes
  typedef enum logic [2:0] {
    EV_IGNORED  = 3'd0,
    EV_ACCEPTED = 3'd1,
    EV_GOOD     = 3'd2,
    EV_BADSUM   = 3'd3,
    EV_OVERFLOW = 3'd4,
    EV_READ     = 3'd5
  } event_t;

  // one result item
  typedef struct packed {
    event_t      ev;
    logic [6:0]  flen;
    logic        dhalf;
    logic [7:0]  rdata;
  } result_t;

  localparam logic [7:0] GOOD_SUM    = 8'hFF;
  localparam logic [7:0] DELIM_RESET = 8'h7E;

  // output queue
  localparam int QUEUE_DEPTH = 3;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 2;

endpackage

// ----- rtl/frb_core.sv -----
// ----------------------------------------------------------------------------
// Frame receiver core
// Delimiter hunt, length and checksum tracking, frame buffer memory and the
// result stage that joins the registered memory read data.
// ----------------------------------------------------------------------------
`include "frame_receiver_double_buffer_macros.svh"

module frb_core import frb_pkg::*; #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_action,
  input  logic [7:0]    in_rx_byte,
  input  logic          in_read_half,
  input  logic [6:0]    in_read_offset,
  input  logic          room,
  output logic          push_vld,
  output result_t       push_item
);

  localparam int OFF_W  = $clog2(BUFFER_BYTES);
  localparam int ADDR_W = OFF_W + 1;
  localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_LEN_HI = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_LEN_LO = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_DATA   = CNT_W'(3);
  localparam logic [16:0] BUF_LIMIT  = 17'(BUFFER_BYTES);
  localparam logic [15:0] OFF_LIMIT  = 16'(BUFFER_BYTES);

  // frame buffer, two halves
  logic [7:0] mem [2**ADDR_W];
  logic [7:0] mem_rd_r;

  // receive state
  logic [7:0]       delim_r;
  logic             fill_half_r, fill_half_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [7:0]       sum_r, sum_nxt;

  // result stage
  logic        s1_vld_r;
  event_t      s1_ev_r, s1_ev_nxt;
  logic [6:0]  s1_flen_r, s1_flen_nxt;
  logic        s1_dhalf_r, s1_dhalf_nxt;
  logic        s1_rd_r, s1_rd_nxt;

  logic              acc;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [15:0]       len_full;
  logic [16:0]       len_end;
  logic [CNT_W-1:0]  cnt_inc;
  logic [7:0]        sum_add;

  assign in_ready = room;
  assign acc      = in_valid & in_ready;

  // addresses; writes always land below BUFFER_BYTES within the half
  assign wr_addr  = {fill_half_r, cnt_r[OFF_W-1:0]};
  assign rd_addr  = {in_read_half, OFF_W'(in_read_offset)};
  assign len_full = {len_r[15:8], in_rx_byte};
  assign len_end  = {1'b0, len_r} + 17'd4;
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign sum_add  = sum_r + in_rx_byte;

  // parser next state and result fields
  always_comb begin
    fill_half_nxt = fill_half_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    sum_nxt       = sum_r;
    s1_ev_nxt     = EV_ACCEPTED;
    s1_flen_nxt   = '0;
    s1_dhalf_nxt  = 1'b0;
    s1_rd_nxt     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    if (in_action) begin
      s1_ev_nxt = EV_READ;
      s1_rd_nxt = 16'(in_read_offset) < OFF_LIMIT;
      mem_re    = acc;
    end else if (cnt_r == '0) begin
      if (in_rx_byte != delim_r) begin
        s1_ev_nxt = EV_IGNORED;
      end else begin
        mem_we  = acc;
        cnt_nxt = CNT_LEN_HI;
        sum_nxt = '0;
      end
    end else if (cnt_r == CNT_LEN_HI) begin
      mem_we  = acc;
      len_nxt = {in_rx_byte, 8'h00};
      cnt_nxt = CNT_LEN_LO;
    end else if (cnt_r == CNT_LEN_LO) begin
      mem_we  = acc;
      len_nxt = len_full;
      if (({1'b0, len_full} + 17'd4) > BUF_LIMIT) begin
        s1_ev_nxt = EV_OVERFLOW;
        cnt_nxt   = '0;
      end else begin
        cnt_nxt = CNT_DATA;
        sum_nxt = '0;
      end
    end else begin
      mem_we  = acc;
      sum_nxt = sum_add;
      cnt_nxt = cnt_inc;
      if (17'(cnt_inc) >= len_end) begin
        if (sum_add == GOOD_SUM) begin
          s1_ev_nxt     = EV_GOOD;
          s1_flen_nxt   = len_r[6:0];
          s1_dhalf_nxt  = fill_half_r;
          fill_half_nxt = ~fill_half_r;
        end else begin
          s1_ev_nxt = EV_BADSUM;
        end
        cnt_nxt = '0;
        sum_nxt = '0;
      end
    end
  end

  // delimiter register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RESET;
    end else if (cfg_wr_en) begin
      delim_r <= cfg_wr_data;
    end
  end

  // receive state, advances on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_half_r <= 1'b0;
      cnt_r       <= '0;
      len_r       <= '0;
      sum_r       <= '0;
    end else if (acc) begin
      fill_half_r <= fill_half_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      sum_r       <= sum_nxt;
    end
  end

  // one item per edge: a read never meets a write to memory in the same
  // cycle, so stored data is always current
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_rx_byte;
    end
    if (mem_re) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ev_r    <= s1_ev_nxt;
      s1_flen_r  <= s1_flen_nxt;
      s1_dhalf_r <= s1_dhalf_nxt;
      s1_rd_r    <= s1_rd_nxt;
    end
  end

  assign push_vld        = s1_vld_r;
  assign push_item.ev    = s1_ev_r;
  assign push_item.flen  = s1_flen_r;
  assign push_item.dhalf = s1_dhalf_r;
  assign push_item.rdata = s1_rd_r ? mem_rd_r : 8'h00;

  // checks
  `FRB_ASSERT_IMPL(a_good_swaps_half, clk, rst_n, s1_vld_r && (s1_ev_r == EV_GOOD), fill_half_r != s1_dhalf_r, "good frame did not swap buffer halves")
  `FRB_ASSERT_IMPL(a_cnt_in_frame, clk, rst_n, cnt_r >= CNT_DATA, 17'(cnt_r) < len_end, "byte count ran past frame end")
  `FRB_ASSERT_NEXT(a_result_follows, clk, rst_n, acc, s1_vld_r, "accepted item gave no result")

endmodule

// ----- rtl/frb_outq.sv -----
// ----------------------------------------------------------------------------
// Frame receiver result queue
// Three-entry register queue that decouples the result stage from the
// output handshake; reports room for one more item from registers only.
// ----------------------------------------------------------------------------
`include "frame_receiver_double_buffer_macros.svh"

module frb_outq import frb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_vld,
  input  result_t  push_item,
  output logic     room,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  head
);

  result_t           q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  assign out_valid = cnt_r != '0;
  assign head      = q_r[rd_ptr_r];
  assign pop       = out_valid & out_ready;

  // room for an item accepted now, counting the one in the result stage
  assign room = ({1'b0, cnt_r} + {2'b00, push_vld}) < 3'(QUEUE_DEPTH);

  // pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_vld) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    cnt_nxt = cnt_r + QCNT_W'(push_vld) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_vld) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

  // checks
  `FRB_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, push_vld && !pop, cnt_r != QCNT_W'(QUEUE_DEPTH), "result pushed into full queue")
  `FRB_ASSERT_NEXT(a_cnt_tracks, clk, rst_n, 1'b1, cnt_r == ($past(cnt_r) + QCNT_W'($past(push_vld)) - QCNT_W'($past(pop))), "queue count out of step")
  `FRB_ASSERT_NEXT(a_valid_held, clk, rst_n, out_valid && !out_ready, out_valid, "out_valid dropped before accept")

endmodule

// ----- rtl/frame_receiver_double_buffer.sv -----
// ----------------------------------------------------------------------------
// Frame receiver with double buffer
// Length-prefixed serial frame receiver with checksum and swapped halves.
// ----------------------------------------------------------------------------
// Takes one item per clock: either a received byte or a read of one stored
// byte. A frame opens with the start delimiter, carries a 16-bit big-endian
// length, then payload and a checksum byte; the 8-bit sum from offset 3
// through the checksum must be 0xFF. Good frames are reported with their
// half and filling moves to the other half; frames whose length plus four
// exceeds BUFFER_BYTES are dropped when the length completes. Every item
// yields exactly one result, carried through the registered result stage
// (joined with the registered frame memory read) and then the result queue.
// Sustained rate is one item per cycle; in_ready drops only when the
// three-entry result queue is backed up by out_ready.
module frame_receiver_double_buffer import frb_pkg::*; #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_read_half,
  input  logic [6:0]  in_read_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [6:0]  out_frame_length,
  output logic        out_done_half,
  output logic [7:0]  out_read_data
);

  logic    room;
  logic    push_vld;
  result_t push_item;
  result_t head;

  // receive path and frame memory
  frb_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_rx_byte     (in_rx_byte),
    .in_read_half   (in_read_half),
    .in_read_offset (in_read_offset),
    .room           (room),
    .push_vld       (push_vld),
    .push_item      (push_item)
  );

  // result queue
  frb_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (push_vld),
    .push_item (push_item),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_event_res    = head.ev;
  assign out_frame_length = head.flen;
  assign out_done_half    = head.dhalf;
  assign out_read_data    = head.rdata;

endmodule

// ----- tb/frb_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame receiver testbench package
// Input action codes shared by the stimulus top and the checker.
// ----------------------------------------------------------------------------
package frb_tb_pkg;

  // what one input item asks of the block
  typedef enum logic {
    ACT_RECEIVE = 1'b0,
    ACT_READ    = 1'b1
  } action_t;

endpackage

// ----- tb/frame_receiver_double_buffer_checker.sv -----
// ----------------------------------------------------------------------------
// Frame receiver checker
// Watches the config port and both channels, predicts every result from the
// accepted items and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module frame_receiver_double_buffer_checker
  import frb_pkg::*;
  import frb_tb_pkg::*;
#(
  parameter int BUFFER_BYTES = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [7:0]                  cfg_wr_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_action,
  input  logic [7:0]                  in_rx_byte,
  input  logic                        in_read_half,
  input  logic [6:0]                  in_read_offset,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [2:0]                  out_event_res,
  input  logic [6:0]                  out_frame_length,
  input  logic                        out_done_half,
  input  logic [7:0]                  out_read_data,
  output int                          fail_count,
  output int                          results_pending,
  output logic [2*BUFFER_BYTES-1:0]   stored_map
);

  localparam int STORE_DEPTH = 2 * BUFFER_BYTES;
  localparam int REPORT_CAP  = 100;

  // predicted block state
  logic [7:0]             delim;
  logic [7:0]             frame_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] written;
  logic                   fill_sel;
  logic [7:0]             pos_cnt;
  logic [15:0]            len_field;
  logic [7:0]             csum;

  result_t expected_results [$];
  int      n_fail = 0;

  // byte lands in the half being filled; past the half it is dropped
  function automatic void store_byte(int pos, logic [7:0] b);
    int idx;
    if (pos < BUFFER_BYTES) begin
      idx            = int'(fill_sel) * BUFFER_BYTES + pos;
      frame_mem[idx] = b;
      written[idx]   = 1'b1;
    end
  endfunction

  // one accepted item -> its result, state advanced
  function automatic result_t step_receiver(logic act, logic [7:0] b, logic rd_half,
                                            logic [6:0] rd_off);
    result_t r;
    r    = '0;
    r.ev = EV_ACCEPTED;
    if (act == ACT_READ) begin
      r.ev = EV_READ;
      if (int'(rd_off) < BUFFER_BYTES)
        r.rdata = frame_mem[int'(rd_half) * BUFFER_BYTES + int'(rd_off)];
    end else if (pos_cnt == 8'd0) begin
      // hunting for the delimiter
      if (b != delim) begin
        r.ev = EV_IGNORED;
      end else begin
        store_byte(0, b);
        pos_cnt = 8'd1;
        csum    = 8'd0;
      end
    end else if (pos_cnt == 8'd1) begin
      store_byte(1, b);
      len_field = {b, 8'h00};
      pos_cnt   = 8'd2;
    end else if (pos_cnt == 8'd2) begin
      store_byte(2, b);
      len_field[7:0] = b;
      // frame cannot fit: drop now
      if (int'(len_field) + 4 > BUFFER_BYTES) begin
        r.ev    = EV_OVERFLOW;
        pos_cnt = 8'd0;
      end else begin
        pos_cnt = 8'd3;
        csum    = 8'd0;
      end
    end else begin
      // payload and checksum, summed
      store_byte(int'(pos_cnt), b);
      csum    = csum + b;
      pos_cnt = pos_cnt + 8'd1;
      if (int'(pos_cnt) >= int'(len_field) + 4) begin
        if (csum == GOOD_SUM) begin
          r.ev     = EV_GOOD;
          r.flen   = len_field[6:0];
          r.dhalf  = fill_sel;
          fill_sel = ~fill_sel;
        end else begin
          r.ev = EV_BADSUM;
        end
        pos_cnt = 8'd0;
        csum    = 8'd0;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      n_fail++;
      if (n_fail <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // track config, predict on input, compare on output
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      delim     = DELIM_RESET;
      written   = '0;
      fill_sel  = 1'b0;
      pos_cnt   = 8'd0;
      len_field = 16'd0;
      csum      = 8'd0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en)
        delim = cfg_wr_data;
      if (in_valid && in_ready)
        expected_results.push_back(step_receiver(in_action, in_rx_byte, in_read_half,
                                                 in_read_offset));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          n_fail++;
          if (n_fail <= REPORT_CAP)
            $display("%0t: unexpected result, expected none, actual event_res %0d",
                     $time, out_event_res);
        end else begin
          want = expected_results.pop_front();
          check_field("event_res", 8'(want.ev), 8'(out_event_res));
          check_field("frame_length", 8'(want.flen), 8'(out_frame_length));
          check_field("done_half", 8'(want.dhalf), 8'(out_done_half));
          check_field("read_data", want.rdata, out_read_data);
        end
      end
    end
    fail_count      <= n_fail;
    results_pending <= expected_results.size();
    stored_map      <= written;
  end

endmodule

// ----- tb/tb_frame_receiver_double_buffer.sv -----
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Directed frames and reads, then random framed traffic over four delimiter
// settings with varied sender/receiver idling; a checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_frame_receiver_double_buffer;
  import frb_pkg::*;
  import frb_tb_pkg::*;

  localparam int BUF_BYTES       = 128;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TIMEOUT_CYCLES  = 200000;

  logic                     clk;
  logic                     rst_n       = 1'b0;
  logic                     cfg_wr_en   = 1'b0;
  logic [7:0]               cfg_wr_data = 8'h00;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic                     in_action   = ACT_RECEIVE;
  logic [7:0]               in_rx_byte  = 8'h00;
  logic                     in_read_half   = 1'b0;
  logic [6:0]               in_read_offset = 7'd0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic [2:0]               out_event_res;
  logic [6:0]               out_frame_length;
  logic                     out_done_half;
  logic [7:0]               out_read_data;

  int                       fail_count;
  int                       results_pending;
  logic [2*BUF_BYTES-1:0]   stored_map;

  // stimulus knobs
  int         snd_idle_pct    = 0;
  int         rcv_idle_pct    = 0;
  int         read_mix_pct    = 0;
  logic       hold_off_req    = 1'b0;
  bit         hold_off_served = 1'b0;
  logic [7:0] cur_delim       = DELIM_RESET;
  int         work_items      = 0;

  frame_receiver_double_buffer #(
    .BUFFER_BYTES(BUF_BYTES)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_rx_byte       (in_rx_byte),
    .in_read_half     (in_read_half),
    .in_read_offset   (in_read_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_frame_length (out_frame_length),
    .out_done_half    (out_done_half),
    .out_read_data    (out_read_data)
  );

  frame_receiver_double_buffer_checker #(
    .BUFFER_BYTES(BUF_BYTES)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_rx_byte       (in_rx_byte),
    .in_read_half     (in_read_half),
    .in_read_offset   (in_read_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_frame_length (out_frame_length),
    .out_done_half    (out_done_half),
    .out_read_data    (out_read_data),
    .fail_count       (fail_count),
    .results_pending  (results_pending),
    .stored_map       (stored_map)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Regression FAIL");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_served) begin
        hold_off_served = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // offer one item and hold it until accepted
  task automatic send_item(logic act, logic [7:0] b, logic h, logic [6:0] o);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_rx_byte     <= b;
    in_read_half   <= h;
    in_read_offset <= o;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // read a byte that has already been stored (the map only grows)
  task automatic send_read();
    int   start;
    int   idx;
    logic h;
    logic [6:0] o;
    h     = 1'b0;
    o     = 7'd0;
    start = $urandom_range(0, 2 * BUF_BYTES - 1);
    for (int k = 0; k < 2 * BUF_BYTES; k++) begin
      idx = (start + k) % (2 * BUF_BYTES);
      if (stored_map[idx]) begin
        h = 1'(idx / BUF_BYTES);
        o = 7'(idx % BUF_BYTES);
        break;
      end
    end
    work_items++;
    send_item(ACT_READ, 8'($urandom), h, o);
  endtask

  // received byte, sometimes preceded by a read
  task automatic send_rx(logic [7:0] b);
    if ($urandom_range(0, 99) < read_mix_pct)
      send_read();
    work_items++;
    send_item(ACT_RECEIVE, b, 1'($urandom), 7'($urandom));
  endtask

  // one frame with random content; sometimes oversized, bad or cut short
  task automatic send_frame();
    int          sel;
    int          len;
    int          cut;
    bit          good;
    logic [15:0] len_v;
    logic [7:0]  b;
    logic [7:0]  sum;
    sel = $urandom_range(0, 99);
    if (sel < 65)      len = $urandom_range(0, 12);
    else if (sel < 82) len = $urandom_range(13, 123);
    else if (sel < 88) len = BUF_BYTES - 4;
    else if (sel < 94) len = $urandom_range(BUF_BYTES - 3, BUF_BYTES + 2);
    else               len = $urandom_range(BUF_BYTES + 3, 65535);
    len_v = 16'(len);
    good  = ($urandom_range(0, 99) < 75);
    cut   = ($urandom_range(0, 99) < 5) ? $urandom_range(0, len) : -1;
    send_rx(cur_delim);
    send_rx(len_v[15:8]);
    send_rx(len_v[7:0]);
    if (len + 4 > BUF_BYTES)
      return;
    sum = 8'h00;
    for (int i = 0; i < len; i++) begin
      if (i == cut)
        return;
      b   = 8'($urandom);
      sum = sum + b;
      send_rx(b);
    end
    send_rx(good ? (GOOD_SUM - sum) : 8'($urandom));
  endtask

  // frames with noise between them until n more items have gone in
  task automatic run_traffic(int n);
    int target;
    target = work_items + n;
    while (work_items < target) begin
      if ($urandom_range(0, 99) < 30) begin
        repeat ($urandom_range(1, 3))
          send_item(ACT_RECEIVE, 8'($urandom), 1'($urandom), 7'($urandom));
      end
      send_frame();
    end
  endtask

  // stop offering until every expected result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_delim(logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_delim   = v;
  endtask

  // main sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 32;
    rcv_idle_pct = 54;

    // directed: noise while hunting
    send_item(ACT_RECEIVE, 8'h00, 1'b1, 7'd127);
    // zero length, good checksum, fills the first half
    send_rx(cur_delim);
    send_rx(8'h00);
    send_rx(8'h00);
    send_rx(8'hFF);
    // zero length, bad checksum
    send_rx(cur_delim);
    send_rx(8'h00);
    send_rx(8'h00);
    send_rx(8'h00);
    // oversized by one byte, then the largest length
    send_rx(cur_delim);
    send_rx(8'h00);
    send_rx(8'(BUF_BYTES - 3));
    send_rx(cur_delim);
    send_rx(8'hFF);
    send_rx(8'hFF);
    // delimiter as payload data, good frame in the second half
    send_rx(cur_delim);
    send_rx(8'h00);
    send_rx(8'h01);
    send_rx(cur_delim);
    send_rx(GOOD_SUM - cur_delim);
    // read back: first half, then the byte just written
    send_item(ACT_READ, 8'hA5, 1'b0, 7'd3);
    send_item(ACT_READ, 8'h5A, 1'b1, 7'd4);

    // sender idles less than the receiver
    read_mix_pct = 8;
    run_traffic(430);
    wait_drained();

    // receiver idles less than the sender
    write_delim(8'h00);
    snd_idle_pct = 54;
    rcv_idle_pct = 32;
    run_traffic(430);
    wait_drained();

    // no idling; long receiver hold-off while the sender keeps going
    write_delim(8'hFF);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_off_req <= 1'b1;
    run_traffic(300);
    wait_drained();

    // random delimiter, still no idling
    write_delim(8'($urandom_range(1, 254)));
    run_traffic(220);
    wait_drained();

    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
